>>> hw/rtl/stc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stc_pkg
// Shared constants and types of the space-to-tab compressor.
// ----------------------------------------------------------------------------
package stc_pkg;

    localparam int DEF_MAX_TAB_WIDTH = 16;
    localparam int DEF_COLUMN_BITS   = 16;

    localparam int CFG_DATA_W = 5;

    localparam logic [CFG_DATA_W-1:0] TAB_WIDTH_RESET = 5'd8;

    localparam logic CFG_TAB_WIDTH    = 1'b0;
    localparam logic CFG_LEADING_ONLY = 1'b1;

    localparam logic [7:0] CH_TAB   = 8'd9;
    localparam logic [7:0] CH_NL    = 8'd10;
    localparam logic [7:0] CH_SPACE = 8'd32;

    localparam logic [1:0] KIND_END   = 2'd0;
    localparam logic [1:0] KIND_SPACE = 2'd1;
    localparam logic [1:0] KIND_TAB   = 2'd2;
    localparam logic [1:0] KIND_OTHER = 2'd3;

    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_PTR_W = 1;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] ch;
    } stc_item_t;

endpackage

>>> hw/rtl/stc_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stc_front
// Accepts input items, classifies them and holds them in a short queue.
// ----------------------------------------------------------------------------
module stc_front
    import stc_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  logic [7:0] char_in,
    input  logic      line_end,
    output logic      q_valid,
    output stc_item_t q_item,
    input  logic      q_pop
);

    stc_item_t                slot_reg [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0]   wr_ptr_reg;
    logic [QUEUE_PTR_W-1:0]   wr_ptr_next;
    logic [QUEUE_PTR_W-1:0]   rd_ptr_reg;
    logic [QUEUE_PTR_W-1:0]   rd_ptr_next;
    logic [QUEUE_PTR_W:0]     count_reg;
    logic [QUEUE_PTR_W:0]     count_next;
    stc_item_t                new_item;
    logic                     push;
    logic                     pop;

    // classification
    always_comb
    begin
        new_item.ch = char_in;
        if (line_end)
        begin
            new_item.kind = KIND_END;
        end
        else if (char_in == CH_SPACE)
        begin
            new_item.kind = KIND_SPACE;
        end
        else if (char_in == CH_TAB)
        begin
            new_item.kind = KIND_TAB;
        end
        else
        begin
            new_item.kind = KIND_OTHER;
        end
    end

    assign in_ready = (count_reg != QUEUE_DEPTH[QUEUE_PTR_W:0]);
    assign q_valid  = (count_reg != '0);
    assign q_item   = slot_reg[rd_ptr_reg];
    assign push     = in_valid && in_ready;
    assign pop      = q_pop && q_valid;

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg + {{QUEUE_PTR_W{1'b0}}, push}
                      - {{QUEUE_PTR_W{1'b0}}, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= new_item;
        end
    end

endmodule

>>> hw/rtl/stc_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stc_back
// Column tracking and emission of tabs, spaces and passed characters.
// ----------------------------------------------------------------------------
module stc_back
    import stc_pkg::*;
#(
    parameter int MAX_TAB_WIDTH = DEF_MAX_TAB_WIDTH,
    parameter int COLUMN_BITS   = DEF_COLUMN_BITS,
    localparam int TW           = $clog2(MAX_TAB_WIDTH + 1)
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic [TW-1:0] tab_eff,
    input  logic          leading_only,
    input  logic          q_valid,
    input  stc_item_t     q_item,
    output logic          q_pop,
    output logic          out_valid,
    input  logic          out_ready,
    output logic [7:0]    char_out,
    output logic          last
);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_NORM   = 3'd1;
    localparam logic [2:0] ST_TABADV = 3'd2;
    localparam logic [2:0] ST_EAGER  = 3'd3;
    localparam logic [2:0] ST_FLUSH  = 3'd4;
    localparam logic [2:0] ST_CHAR   = 3'd5;

    localparam logic [COLUMN_BITS-1:0] ONE = {{(COLUMN_BITS-1){1'b0}}, 1'b1};

    logic [2:0]             state_reg;
    logic [2:0]             state_next;
    logic [COLUMN_BITS-1:0] oc_reg;
    logic [COLUMN_BITS-1:0] oc_next;
    logic [COLUMN_BITS-1:0] ic_reg;
    logic [COLUMN_BITS-1:0] ic_next;
    logic [COLUMN_BITS-1:0] stop_reg;
    logic [COLUMN_BITS-1:0] stop_next;
    logic                   pass_reg;
    logic                   pass_next;
    stc_item_t              item_reg;
    stc_item_t              item_next;
    logic                   out_valid_reg;
    logic                   out_valid_next;
    logic [7:0]             char_out_reg;
    logic [7:0]             char_out_next;
    logic                   last_reg;
    logic                   last_next;

    logic [COLUMN_BITS-1:0] t_col;
    logic [COLUMN_BITS-1:0] ic_less;
    logic [COLUMN_BITS-1:0] oc_inc;
    logic                   room;
    logic                   is_end;
    logic                   more;

    assign t_col     = {{(COLUMN_BITS-TW){1'b0}}, tab_eff};
    assign ic_less   = ic_reg - t_col;
    assign oc_inc    = oc_reg + ONE;
    assign room      = !out_valid_reg || out_ready;
    assign is_end    = (item_reg.kind == KIND_END);
    assign q_pop     = (state_reg == ST_IDLE) && q_valid;
    assign out_valid = out_valid_reg;
    assign char_out  = char_out_reg;
    assign last      = last_reg;

    always_comb
    begin
        state_next     = state_reg;
        oc_next        = oc_reg;
        ic_next        = ic_reg;
        stop_next      = stop_reg;
        pass_next      = pass_reg;
        item_next      = item_reg;
        out_valid_next = (out_valid_reg && out_ready) ? 1'b0 : out_valid_reg;
        char_out_next  = char_out_reg;
        last_next      = last_reg;
        more           = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (q_valid)
                begin
                    item_next  = q_item;
                    state_next = ST_NORM;
                end
            end

            ST_NORM:
            begin
                if (oc_reg >= t_col)
                begin
                    // bring the output column back into the first tab cell
                    oc_next = oc_reg - t_col;
                    ic_next = ic_less;
                end
                else if (item_reg.kind == KIND_END)
                begin
                    if (pass_reg)
                    begin
                        oc_next    = '0;
                        ic_next    = '0;
                        pass_next  = 1'b0;
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        state_next = ST_FLUSH;
                    end
                end
                else if (pass_reg)
                begin
                    state_next = ST_CHAR;
                end
                else if (item_reg.kind == KIND_SPACE)
                begin
                    ic_next    = ic_reg + ONE;
                    state_next = ST_EAGER;
                end
                else if (item_reg.kind == KIND_TAB)
                begin
                    stop_next  = t_col;
                    state_next = ST_TABADV;
                end
                else if (oc_reg == ic_reg)
                begin
                    state_next = ST_CHAR;
                end
                else
                begin
                    state_next = ST_FLUSH;
                end
            end

            ST_TABADV:
            begin
                if (stop_reg <= ic_reg)
                begin
                    stop_next = stop_reg + t_col;
                end
                else
                begin
                    ic_next    = stop_reg;
                    state_next = ST_EAGER;
                end
            end

            ST_EAGER:
            begin
                if ((t_col <= ic_reg) && (oc_inc < ic_reg))
                begin
                    if (room)
                    begin
                        more           = (t_col <= ic_less) && (ONE < ic_less);
                        out_valid_next = 1'b1;
                        char_out_next  = CH_TAB;
                        last_next      = !more;
                        oc_next        = '0;
                        ic_next        = ic_less;
                        if (!more)
                        begin
                            state_next = ST_IDLE;
                        end
                    end
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end

            ST_FLUSH:
            begin
                if ((t_col <= ic_reg) && (oc_reg < ic_reg) && (oc_inc != ic_reg))
                begin
                    if (room)
                    begin
                        more           = (ic_less != '0);
                        out_valid_next = 1'b1;
                        char_out_next  = CH_TAB;
                        last_next      = is_end && !more;
                        oc_next        = '0;
                        ic_next        = ic_less;
                        if (is_end && !more)
                        begin
                            oc_next    = '0;
                            ic_next    = '0;
                            pass_next  = 1'b0;
                            state_next = ST_IDLE;
                        end
                    end
                end
                else if (oc_reg < ic_reg)
                begin
                    if (room)
                    begin
                        more           = (oc_inc < ic_reg);
                        out_valid_next = 1'b1;
                        char_out_next  = CH_SPACE;
                        last_next      = is_end && !more;
                        oc_next        = oc_inc;
                        if (is_end && !more)
                        begin
                            oc_next    = '0;
                            ic_next    = '0;
                            pass_next  = 1'b0;
                            state_next = ST_IDLE;
                        end
                    end
                end
                else if (is_end)
                begin
                    oc_next    = '0;
                    ic_next    = '0;
                    pass_next  = 1'b0;
                    state_next = ST_IDLE;
                end
                else
                begin
                    state_next = ST_CHAR;
                end
            end

            ST_CHAR:
            begin
                if (room)
                begin
                    out_valid_next = 1'b1;
                    char_out_next  = item_reg.ch;
                    last_next      = 1'b1;
                    state_next     = ST_IDLE;
                    if (!pass_reg)
                    begin
                        if (leading_only || (item_reg.ch == CH_NL))
                        begin
                            pass_next = 1'b1;
                            oc_next   = '0;
                            ic_next   = '0;
                        end
                        else
                        begin
                            oc_next = oc_inc;
                            ic_next = oc_inc;
                        end
                    end
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            oc_reg        <= '0;
            ic_reg        <= '0;
            pass_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            oc_reg        <= oc_next;
            ic_reg        <= ic_next;
            pass_reg      <= pass_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        stop_reg     <= stop_next;
        item_reg     <= item_next;
        char_out_reg <= char_out_next;
        last_reg     <= last_next;
    end

endmodule

>>> hw/rtl/space_to_tab_compressor.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// space_to_tab_compressor
// Rewrites whitespace runs of a text line in the fewest tabs and spaces.
// ----------------------------------------------------------------------------
// One character per item goes in; the characters that come out are passed
// characters, tabs and spaces. The front classifies each item into a
// two-entry queue, so up to two items are taken while the back is busy.
// The back takes one item at a time from the queue: it takes it in IDLE and
// decodes it in NORM, then a passed or ordinary character with nothing
// pending goes on to CHAR, a space to EAGER, which emits the tabs that are
// due, and a tab first advances its stop in TABADV past the input column,
// then the same as a space. An ordinary character after pending whitespace
// goes through FLUSH, which emits each pending tab or space, and then CHAR;
// a line end goes through FLUSH alone, and in pass-through mode straight
// back to IDLE. The decode step repeats, one tab width at a time, while the
// output column lies at or beyond the first tab stop, which happens after
// an ordinary character that reaches a tab stop and after the tab width
// shrinks mid-line. Results leave through one output register; a result
// that is due while the register still holds an unaccepted one stalls the
// back until it is taken, while the queue keeps accepting items until full.
// ----------------------------------------------------------------------------
module space_to_tab_compressor
    import stc_pkg::*;
#(
    parameter int MAX_TAB_WIDTH = DEF_MAX_TAB_WIDTH,
    parameter int COLUMN_BITS   = DEF_COLUMN_BITS
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [7:0]            char_in,
    input  logic                  line_end,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [7:0]            char_out,
    output logic                  last,
    input  logic                  cfg_we,
    input  logic                  cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata
);

    localparam int TW    = $clog2(MAX_TAB_WIDTH + 1);
    localparam int CMP_W = (TW > CFG_DATA_W) ? TW : CFG_DATA_W;

    localparam logic [CMP_W-1:0] MAX_CMP = MAX_TAB_WIDTH[CMP_W-1:0];

    logic [CFG_DATA_W-1:0] tab_width_reg;
    logic                  leading_only_reg;
    logic [CMP_W-1:0]      tab_ext;
    logic [CMP_W-1:0]      tab_clamp;
    logic [TW-1:0]         tab_eff;
    logic                  q_valid;
    stc_item_t             q_item;
    logic                  q_pop;

    // tab width limited to 1..MAX_TAB_WIDTH
    always_comb
    begin
        tab_ext = CMP_W'(tab_width_reg);
        if (tab_ext == '0)
        begin
            tab_clamp = {{(CMP_W-1){1'b0}}, 1'b1};
        end
        else if (tab_ext > MAX_CMP)
        begin
            tab_clamp = MAX_CMP;
        end
        else
        begin
            tab_clamp = tab_ext;
        end
        tab_eff = tab_clamp[TW-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tab_width_reg    <= TAB_WIDTH_RESET;
            leading_only_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            if (cfg_addr == CFG_TAB_WIDTH)
            begin
                tab_width_reg <= cfg_wdata;
            end
            else
            begin
                leading_only_reg <= cfg_wdata[0];
            end
        end
    end

    stc_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .char_in  (char_in),
        .line_end (line_end),
        .q_valid  (q_valid),
        .q_item   (q_item),
        .q_pop    (q_pop)
    );

    stc_back #(
        .MAX_TAB_WIDTH (MAX_TAB_WIDTH),
        .COLUMN_BITS   (COLUMN_BITS)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .tab_eff      (tab_eff),
        .leading_only (leading_only_reg),
        .q_valid      (q_valid),
        .q_item       (q_item),
        .q_pop        (q_pop),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .char_out     (char_out),
        .last         (last)
    );

endmodule

>>> bench/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the space-to-tab compressor.
// ----------------------------------------------------------------------------
// A queue of character items feeds a valid/ready driver. Accepted items run
// through a behavioral unexpand predictor that fills a queue of expected
// output characters. A monitor checks every accepted result against that
// queue. Both sides insert random gaps and stalls outside steady phases.
// Tab width and leading-only mode change between phases while the block
// is idle, sometimes in the middle of a line.
// ----------------------------------------------------------------------------
module tb_top
    import stc_pkg::*;
;

    localparam int          MAX_TAB      = DEF_MAX_TAB_WIDTH;
    localparam int          MAX_BURST    = 18;
    localparam logic [31:0] COL_MASK     = 32'h0000_FFFF;
    localparam int          DRAIN_CYCLES = 64;
    localparam int          CYCLE_LIMIT  = 500000;
    localparam int          PHASE_ITEMS  = 12;

    typedef struct {
        logic [7:0] ch;
        logic       eol;
    } char_item_t;

    typedef struct {
        logic [7:0] ch;
        logic       is_last;
    } out_char_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  in_valid = 1'b0;
    logic                  in_ready;
    logic [7:0]            char_in = 8'd0;
    logic                  line_end = 1'b0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    logic [7:0]            char_out;
    logic                  last;
    logic                  cfg_we = 1'b0;
    logic                  cfg_addr = CFG_TAB_WIDTH;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    char_item_t pending_items[$];
    out_char_t  expected_chars[$];
    logic [7:0] burst[$];

    // predictor state
    logic [CFG_DATA_W-1:0] tab_width_copy = TAB_WIDTH_RESET;
    logic                  leading_only_copy = 1'b0;
    logic [31:0]           col_in = '0;
    logic [31:0]           col_out = '0;
    logic                  passing = 1'b0;

    logic steady = 1'b0;
    int   gap_left = 0;
    int   hold_left = 0;
    int   err_count = 0;
    int   cycles = 0;
    int   queued_items = 0;

    space_to_tab_compressor u_dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .char_in   (char_in),
        .line_end  (line_end),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .char_out  (char_out),
        .last      (last),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    initial
    begin
        forever #10 clk = ~clk;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(4, 25);
    endfunction

    function automatic logic [31:0] stop_after(logic [31:0] c, logic [31:0] t);
        return c - (c % t) + t;
    endfunction

    function automatic void emit_char(logic [7:0] ch);
        if (burst.size() < MAX_BURST)
            burst.push_back(ch);
    endfunction

    // keep both columns small, only the difference and tab phase matter
    function automatic void realign(logic [31:0] t);
        logic [31:0] k;
        k = col_out - (col_out % t);
        col_out = (col_out - k) & COL_MASK;
        col_in = (col_in - k) & COL_MASK;
    endfunction

    function automatic void emit_sure_tabs(logic [31:0] t);
        while (stop_after(col_out, t) <= col_in && col_out + 1 < col_in)
        begin
            emit_char(CH_TAB);
            col_out = stop_after(col_out, t);
        end
        realign(t);
    endfunction

    function automatic void flush_gap(logic [31:0] t);
        while (stop_after(col_out, t) <= col_in && col_out + 1 != col_in)
        begin
            emit_char(CH_TAB);
            col_out = stop_after(col_out, t);
        end
        while (col_out < col_in)
        begin
            emit_char(CH_SPACE);
            col_out = col_out + 1;
        end
    endfunction

    function automatic void predict_unexpand(logic [7:0] ch, logic eol);
        logic [31:0] t;
        t = tab_width_copy;
        if (t < 1)
            t = 1;
        if (t > MAX_TAB)
            t = MAX_TAB;
        burst.delete();
        if (eol)
        begin
            if (!passing)
                flush_gap(t);
            col_in = '0;
            col_out = '0;
            passing = 1'b0;
        end
        else if (passing)
            emit_char(ch);
        else if (ch == CH_SPACE)
        begin
            col_in = col_in + 1;
            emit_sure_tabs(t);
        end
        else if (ch == CH_TAB)
        begin
            col_in = stop_after(col_in, t);
            emit_sure_tabs(t);
        end
        else
        begin
            flush_gap(t);
            emit_char(ch);
            if (leading_only_copy || ch == CH_NL)
            begin
                passing = 1'b1;
                col_in = '0;
                col_out = '0;
            end
            else
            begin
                col_out = col_out + 1;
                col_in = col_out;
                realign(t);
            end
        end
        foreach (burst[i])
            expected_chars.push_back('{ch: burst[i], is_last: (i == burst.size() - 1)});
    endfunction

    task automatic report_mismatch(string what, logic [7:0] got, logic [7:0] want);
        if (err_count < 40)
            $display("mismatch: %s got %02h want %02h at cycle %0d", what, got, want, cycles);
        err_count++;
    endtask

    // driver
    always @(posedge clk or negedge rst_n)
    begin : driver
        logic       take;
        char_item_t nxt;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            char_in <= 8'd0;
            line_end <= 1'b0;
            gap_left <= 0;
        end
        else
        begin
            take = in_valid && in_ready;
            if (take)
                predict_unexpand(char_in, line_end);
            if (in_valid && !take)
            begin
                // hold the item until it is taken
            end
            else if (gap_left != 0)
            begin
                in_valid <= 1'b0;
                gap_left <= gap_left - 1;
            end
            else if (pending_items.size() != 0)
            begin
                nxt = pending_items.pop_front();
                in_valid <= 1'b1;
                char_in <= nxt.ch;
                line_end <= nxt.eol;
                gap_left <= steady ? 0 : pick_gap();
            end
            else
                in_valid <= 1'b0;
        end
    end

    // monitor
    always @(posedge clk or negedge rst_n)
    begin : monitor
        out_char_t want;
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            hold_left <= 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (expected_chars.size() == 0)
                    report_mismatch("unexpected result", char_out, 8'h00);
                else
                begin
                    want = expected_chars.pop_front();
                    if (char_out !== want.ch)
                        report_mismatch("char_out", char_out, want.ch);
                    if (last !== want.is_last)
                        report_mismatch("last", {7'd0, last}, {7'd0, want.is_last});
                end
            end
            if (hold_left != 0)
            begin
                hold_left <= hold_left - 1;
                out_ready <= 1'b0;
            end
            else if (!steady && $urandom_range(0, 7) == 0)
            begin
                hold_left <= pick_gap();
                out_ready <= 1'b0;
            end
            else
                out_ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("tb_top: errors");
            $finish;
        end
    end

    task automatic add_char(logic [7:0] ch);
        pending_items.push_back('{ch: ch, eol: 1'b0});
        queued_items++;
    endtask

    task automatic add_eol(logic [7:0] ch);
        pending_items.push_back('{ch: ch, eol: 1'b1});
        queued_items++;
    endtask

    task automatic add_text(string s);
        for (int i = 0; i < s.len(); i++)
            add_char(s[i]);
    endtask

    task automatic add_random_line();
        int len;
        int r;
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 40) : $urandom_range(0, 12);
        for (int i = 0; i < len; i++)
        begin
            r = $urandom_range(0, 99);
            if (r < 35)
                add_char(CH_SPACE);
            else if (r < 55)
                add_char(CH_TAB);
            else if (r < 58)
                add_char(CH_NL);
            else if (r < 66)
                add_char(8'($urandom_range(0, 255)));
            else
                add_char(8'($urandom_range(33, 126)));
        end
        // some lines run on into the next line, or into the next phase
        if ($urandom_range(0, 4) != 0)
            add_eol(8'($urandom_range(0, 255)));
    endtask

    task automatic write_reg(logic addr, logic [CFG_DATA_W-1:0] data);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_addr <= addr;
        cfg_wdata <= data;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (addr == CFG_TAB_WIDTH)
            tab_width_copy = data;
        else
            leading_only_copy = data[0];
    endtask

    task automatic wait_idle();
        do
            @(negedge clk);
        while (pending_items.size() != 0 || in_valid || expected_chars.size() != 0);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    initial
    begin : stimulus
        logic [CFG_DATA_W-1:0] widths[8];
        logic                  modes[8];
        int                    mark;
        widths = '{5'd0, 5'd16, 5'd1, 5'd31, 5'd5, 5'd8,
                   5'($urandom_range(0, 31)), 5'($urandom_range(0, 31))};
        modes = '{1'b0, 1'b1, 1'b0, 1'b0, 1'b1, 1'b0,
                  1'($urandom_range(0, 1)), 1'($urandom_range(0, 1))};
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // directed lines at reset settings
        add_char(8'h00);
        add_text("       \t ");
        add_char(8'hFF);
        add_text("\t  ");
        add_eol(8'hFF);
        add_eol(8'h00);
        add_text("a\n  \tb");
        add_eol(8'h00);
        wait_idle();

        for (int p = 0; p < 8; p++)
        begin
            write_reg(CFG_TAB_WIDTH, widths[p]);
            write_reg(CFG_LEADING_ONLY, modes[p]);
            steady = (p % 3 == 2);
            mark = queued_items;
            while (queued_items - mark < PHASE_ITEMS)
                add_random_line();
            wait_idle();
        end

        if (err_count == 0)
            $display("tb_top: clean");
        else
            $display("tb_top: errors");
        $finish;
    end

endmodule
